// ===== design/ssd_pkg.sv =====
// ----------------------------------------------------------------------------
// ssd_pkg
// Types and constants shared by the stack core, its cells and its checker.
// ----------------------------------------------------------------------------
package ssd_pkg;

   localparam int DEPTH    = 16;
   localparam int DATA_W   = 32;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int POS_W    = 4;
   localparam int LEVEL_W  = 5;

   typedef enum logic [1:0] {
      CMD_PUSH   = 2'd0,
      CMD_POP    = 2'd1,
      CMD_FIND   = 2'd2,
      CMD_DELETE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type                   cmd;
      logic signed [DATA_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  data_out;
      logic [POS_W-1:0]          position;
      status_type                status;
      logic [LEVEL_W-1:0]        fill_level;
   } rsp_type;

   // Broadcast from the core to every cell
   typedef struct packed {
      logic                push_en;
      logic                pop_en;
      logic                del_en;
      logic [DATA_W-1:0]   value;
   } cell_ctrl_type;

endpackage

// ===== design/stack_search_delete_core.sv =====
// ----------------------------------------------------------------------------
// stack_search_delete_core
// Bounded LIFO of signed words with push, pop, find and delete-first-match,
// built as a chain of cells with the top of stack in cell 0.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  req_    | in        | req_valid / req_ready   | req_payload (cmd, value)
//  rsp_    | out       | rsp_valid / rsp_ready   | rsp_payload (data_out, position,
//          |           |                         |   status, fill_level)
//
//  One request per cycle while responses are taken; its response appears in the cycle after acceptance.
//  All cells compare in parallel; the first-match flag ripples down the chain.
//  The response register frees as it is taken, so req_ready holds under
//  rsp_ready; a stalled response stalls requests.
//  Reset empties the stack at once; no clearing pass.
// ----------------------------------------------------------------------------
module stack_search_delete_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ssd_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ssd_pkg::rsp_type rsp_payload
);
   import ssd_pkg::*;

   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   cell_ctrl_type      ctrl;
   logic               accept;
   logic               full;
   logic               empty;
   logic               found;
   logic [IDX_W-1:0]   hit_idx;

   logic [DEPTH-1:0]   occupied;
   logic [DEPTH-1:0]   hit_chain;
   logic [DEPTH-1:0]   first_hit;
   logic [DATA_W-1:0]  entries [DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);

   always_comb begin
      ctrl.push_en = accept && (req_payload.cmd == CMD_PUSH) && !full;
      ctrl.pop_en  = accept && (req_payload.cmd == CMD_POP) && !empty;
      ctrl.del_en  = accept && (req_payload.cmd == CMD_DELETE);
      ctrl.value   = req_payload.value;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] upper;
      logic [DATA_W-1:0] lower;
      logic              hin;

      assign occupied[i] = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_top
         assign upper = req_payload.value;
         assign hin   = 1'b0;
      end else begin : g_mid
         assign upper = entries[i-1];
         assign hin   = hit_chain[i-1];
      end

      if (i == DEPTH - 1) begin : g_bottom
         assign lower = '0;
      end else begin : g_link
         assign lower = entries[i+1];
      end

      ssd_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occupied[i]),
         .upper_entry (upper),
         .lower_entry (lower),
         .hit_in      (hin),
         .hit_out     (hit_chain[i]),
         .first_hit   (first_hit[i]),
         .entry       (entries[i])
      );
   end

   assign found = hit_chain[DEPTH-1];

   // one-hot first-match flags to an index
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (first_hit[i]) begin
            hit_idx = hit_idx | IDX_W'(i);
         end
      end
   end

   always_comb begin
      count_in          = count_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_in            = rsp_ff;
      if (accept) begin
         rsp_valid_in        = 1'b1;
         rsp_in.data_out     = '0;
         rsp_in.position     = '0;
         rsp_in.status       = STATUS_OK;
         case (req_payload.cmd)
            CMD_PUSH: begin
               if (full) begin
                  rsp_in.status = STATUS_FULL;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            CMD_POP: begin
               if (empty) begin
                  rsp_in.status = STATUS_EMPTY;
               end else begin
                  count_in        = count_ff - CNT_W'(1);
                  rsp_in.data_out = entries[0];
               end
            end
            CMD_FIND: begin
               if (found) begin
                  rsp_in.position = POS_W'(hit_idx);
               end else begin
                  rsp_in.status = STATUS_NOT_FOUND;
               end
            end
            CMD_DELETE: begin
               if (found) begin
                  rsp_in.position = POS_W'(hit_idx);
                  count_in        = count_ff - CNT_W'(1);
               end else begin
                  rsp_in.status = STATUS_NOT_FOUND;
               end
            end
            default: begin
               rsp_in.status = STATUS_NOT_FOUND;
            end
         endcase
         rsp_in.fill_level = LEVEL_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== design/ssd_cell.sv =====
// ----------------------------------------------------------------------------
// ssd_cell
// One stack slot. Compares its word with the search value, passes the
// "match seen above" flag down the chain and shifts with its neighbours.
// ----------------------------------------------------------------------------
module ssd_cell (
   input  logic                        clock,
   input  ssd_pkg::cell_ctrl_type      ctrl,
   input  logic                        occupied,
   input  logic [ssd_pkg::DATA_W-1:0]  upper_entry,
   input  logic [ssd_pkg::DATA_W-1:0]  lower_entry,
   input  logic                        hit_in,
   output logic                        hit_out,
   output logic                        first_hit,
   output logic [ssd_pkg::DATA_W-1:0]  entry
);
   import ssd_pkg::*;

   logic [DATA_W-1:0] entry_ff;
   logic [DATA_W-1:0] entry_in;
   logic              match;

   assign match     = occupied && (entry_ff == ctrl.value);
   assign first_hit = match && !hit_in;
   assign hit_out   = hit_in || match;
   assign entry     = entry_ff;

   // push moves words away from the top, pop and delete close up towards it
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.push_en) begin
         entry_in = upper_entry;
      end else if (ctrl.pop_en) begin
         entry_in = lower_entry;
      end else if (ctrl.del_en && hit_out) begin
         entry_in = lower_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== design/ssd_checker.sv =====
// ----------------------------------------------------------------------------
// ssd_checker
// Port-level checks on the stack core, bound into the core module.
// ----------------------------------------------------------------------------
module ssd_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  ssd_pkg::rsp_type rsp_payload
);
   import ssd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request gave no response");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == STATUS_FULL)
      |-> rsp_payload.fill_level == LEVEL_W'(DEPTH))
      else $error("full status with stack not full");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == STATUS_EMPTY)
      |-> (rsp_payload.fill_level == '0) && (rsp_payload.data_out == '0))
      else $error("empty status with entries or data");

   a_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == STATUS_NOT_FOUND)
      |-> (rsp_payload.position == '0) && (rsp_payload.data_out == '0))
      else $error("not-found response carries position or data");

endmodule

bind stack_search_delete_core ssd_checker u_ssd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// ===== tb/ssd_checker.sv =====
// ----------------------------------------------------------------------------
// ssd_scoreboard
// Watches both channels of the stack core. It keeps its own copy of the stack
// and predicts one response for every accepted request. Each accepted response
// is compared field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module ssd_scoreboard (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  ssd_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  ssd_pkg::rsp_type rsp_payload,
   output int               fail_count,
   output int               pending,
   output int               checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import ssd_pkg::*;

   logic [DATA_W-1:0] shadow_words [DEPTH];
   int                words_held;
   rsp_type           predicted_rsps [$];

   // Applies one request to the shadow stack and returns the response it causes
   function automatic rsp_type apply_request(req_type r);
      rsp_type e;
      int      hit;
      e   = '0;
      hit = -1;
      case (r.cmd)
         CMD_PUSH: begin
            if (words_held >= DEPTH) begin
               e.status = STATUS_FULL;
            end else begin
               shadow_words[words_held] = r.value;
               words_held++;
            end
         end
         CMD_POP: begin
            if (words_held == 0) begin
               e.status = STATUS_EMPTY;
            end else begin
               words_held--;
               e.data_out = shadow_words[words_held];
            end
         end
         default: begin
            // topmost match wins
            for (int i = words_held - 1; i >= 0; i--) begin
               if (hit < 0 && shadow_words[i] == r.value) hit = i;
            end
            if (hit < 0) begin
               e.status = STATUS_NOT_FOUND;
            end else begin
               e.position = POS_W'(words_held - 1 - hit);
               if (r.cmd == CMD_DELETE) begin
                  for (int j = hit; j < words_held - 1; j++) begin
                     shadow_words[j] = shadow_words[j + 1];
                  end
                  words_held--;
               end
            end
         end
      endcase
      e.fill_level = LEVEL_W'(words_held);
      return e;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         words_held = 0;
         predicted_rsps.delete();
      end else begin
         if (req_valid && req_ready) predicted_rsps.push_back(apply_request(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsps.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = predicted_rsps.pop_front();
               checked++;
               if (rsp_payload.data_out !== want.data_out) begin
                  $error("data_out: expected %0d, got %0d", want.data_out,
                         rsp_payload.data_out);
                  fail_count++;
               end
               if (rsp_payload.position !== want.position) begin
                  $error("position: expected %0d, got %0d", want.position,
                         rsp_payload.position);
                  fail_count++;
               end
               if (rsp_payload.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status,
                         rsp_payload.status);
                  fail_count++;
               end
               if (rsp_payload.fill_level !== want.fill_level) begin
                  $error("fill_level: expected %0d, got %0d", want.fill_level,
                         rsp_payload.fill_level);
                  fail_count++;
               end
            end
         end
      end
      pending = predicted_rsps.size();
   end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the stack core with a directed opening (empty and full store, extreme
// values, duplicates, matches at top, middle and bottom) and then phases of
// random requests biased to fill, drain or mix, with random gaps on both
// channels. The scoreboard beside the core predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ssd_pkg::*;

   typedef enum int {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} phase_type;

   localparam int RANDOM_REQS = 1000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   int fail_count;
   int pending;
   int checked;

   int                cmd_sent [4];
   int                calm_left;
   logic [DATA_W-1:0] value_pool [6];

   stack_search_delete_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   ssd_scoreboard u_scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .fail_count  (fail_count),
      .pending     (pending),
      .checked     (checked)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #8ms;
      $display("== FAIL ==");
      $finish;
   end

   // Mostly no gap, some short, a few long; now and then a stretch with none
   function automatic int pick_gap();
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) calm_left = $urandom_range(20, 60);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Small pool so that finds and deletes hit, plus extremes and raw noise
   function automatic logic [DATA_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) value_pool[$urandom_range(0, 5)] = $urandom();
      if (r < 60) return value_pool[$urandom_range(0, 5)];
      if (r < 75) begin
         case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
         endcase
      end
      return $urandom();
   endfunction

   function automatic cmd_type pick_cmd(phase_type ph);
      int r;
      r = $urandom_range(0, 99);
      case (ph)
         PHASE_FILL: begin
            if (r < 70) return CMD_PUSH;
            if (r < 80) return CMD_POP;
            if (r < 90) return CMD_FIND;
            return CMD_DELETE;
         end
         PHASE_DRAIN: begin
            if (r < 10) return CMD_PUSH;
            if (r < 50) return CMD_POP;
            if (r < 70) return CMD_FIND;
            return CMD_DELETE;
         end
         default: return cmd_type'(r % 4);
      endcase
   endfunction

   // Leaves the next falling edge for the caller; valid is left high
   task automatic send_request(input cmd_type c, input logic [DATA_W-1:0] v);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_payload = '{cmd: c, value: v};
      do @(posedge clock); while (!req_ready);
      cmd_sent[c]++;
      @(negedge clock);
   endtask

   // Response side: stretches of steady ready, short stalls, rare long ones
   initial begin : rsp_pacing
      int   r;
      int   span;
      logic level;
      rsp_ready = 1'b0;
      forever begin
         r = $urandom_range(0, 99);
         if (r < 35) begin
            level = 1'b1;
            span  = $urandom_range(20, 80);
         end else if (r < 75) begin
            level = 1'b1;
            span  = $urandom_range(1, 4);
         end else if (r < 95) begin
            level = 1'b0;
            span  = $urandom_range(1, 3);
         end else begin
            level = 1'b0;
            span  = $urandom_range(10, 50);
         end
         repeat (span) begin
            @(negedge clock);
            rsp_ready = level;
         end
      end
   end

   initial begin : stimulus
      phase_type ph;
      int        phase_left;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      calm_left   = 0;
      phase_left  = 0;
      ph          = PHASE_FILL;
      foreach (cmd_sent[i]) cmd_sent[i] = 0;
      foreach (value_pool[i]) value_pool[i] = $urandom();
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7FFF_FFFF;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty store
      send_request(CMD_POP, 32'h0);
      send_request(CMD_FIND, 32'h0);
      send_request(CMD_DELETE, 32'h0);
      // extremes and a duplicate of the bottom value
      send_request(CMD_PUSH, 32'h7FFF_FFFF);
      send_request(CMD_PUSH, 32'h8000_0000);
      send_request(CMD_PUSH, 32'h0000_0000);
      send_request(CMD_PUSH, 32'hFFFF_FFFF);
      send_request(CMD_PUSH, 32'h7FFF_FFFF);
      send_request(CMD_FIND, 32'h7FFF_FFFF);
      send_request(CMD_FIND, 32'h8000_0000);
      send_request(CMD_FIND, 32'h0000_0005);
      send_request(CMD_DELETE, 32'h8000_0000);
      send_request(CMD_DELETE, 32'h7FFF_FFFF);
      // fill to the brim, overflow, then match the bottom entry
      for (int i = 0; i < 13; i++) begin
         send_request(CMD_PUSH, (i % 2) ? 32'h5555_5555 : 32'hAAAA_AAAA);
      end
      send_request(CMD_PUSH, 32'h1234_5678);
      send_request(CMD_FIND, 32'h7FFF_FFFF);

      for (int n = 0; n < RANDOM_REQS; n++) begin
         if (phase_left == 0) begin
            ph         = phase_type'($urandom_range(0, 2));
            phase_left = $urandom_range(20, 60);
         end
         phase_left--;
         send_request(pick_cmd(ph), pick_value());
      end
      req_valid = 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);

      $display("Sent %0d push, %0d pop, %0d find, %0d delete requests;",
               cmd_sent[CMD_PUSH], cmd_sent[CMD_POP], cmd_sent[CMD_FIND],
               cmd_sent[CMD_DELETE]);
      $display("%0d responses checked against the shadow stack, %0d mismatches.",
               checked, fail_count);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/ssd_pkg.sv
design/ssd_cell.sv
design/stack_search_delete_core.sv
design/ssd_checker.sv
tb/ssd_checker.sv
tb/testbench.sv
